// ===== src/cca_pkg.sv =====
package cca_pkg;

    localparam int unsigned CFG_W      = 16;
    localparam int unsigned CNT_W      = 16;
    localparam int unsigned CMD_W      = 3;
    localparam int unsigned OUTST_W    = 32;
    localparam int unsigned WIDE_W     = 34;
    localparam int unsigned JOBS_W     = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned S_TDATA_W  = 24;
    localparam int unsigned M_TDATA_W  = 24;

    localparam logic [CFG_W-1:0] MAX_OUTST_RESET  = 16'd1000;
    localparam logic [CFG_W-1:0] CHUNKS_MRG_RESET = 16'd100;
    localparam logic [JOBS_W-1:0] JOBS_MAX        = 16'hFFFF;

    localparam logic signed [WIDE_W-1:0] I32_MAX = 34'sd2147483647;
    localparam logic signed [WIDE_W-1:0] I32_MIN = -34'sd2147483648;
    localparam logic signed [WIDE_W-1:0] PEND_MAX = 34'sd65535;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADMIT_QUERY  = 3'd0,
        CMD_MERGE_QUERY  = 3'd1,
        CMD_TASK_START   = 3'd2,
        CMD_TASK_FINISH  = 3'd3,
        CMD_ACCOUNT      = 3'd4,
        CMD_MERGE_START  = 3'd5,
        CMD_MERGE_FINISH = 3'd6,
        CMD_TASK_DONE    = 3'd7
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_OUTSTANDING = 2'd0,
        REG_CHUNKS_PER_MERGE = 2'd1
    } cfg_idx_t;

    typedef struct packed {
        cmd_t                    cmd;
        logic signed [CNT_W-1:0] chunk_count;
    } item_t;

    typedef struct packed {
        logic [CFG_W-1:0] max_outstanding_chunks;
        logic [CFG_W-1:0] chunks_per_merge;
    } cfg_t;

    typedef struct packed {
        logic             admit;
        logic             merge_wanted;
        logic [CFG_W-1:0] pending_limit;
        logic             flush_mode;
        logic             done_flag;
        logic             changed;
        logic             underflow_error;
    } result_t;

    function automatic logic signed [OUTST_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [OUTST_W-1:0] r;
        if (v > I32_MAX)
            r = I32_MAX[OUTST_W-1:0];
        else if (v < I32_MIN)
            r = I32_MIN[OUTST_W-1:0];
        else
            r = v[OUTST_W-1:0];
        return r;
    endfunction

    function automatic logic signed [OUTST_W-1:0] floor0(input logic signed [OUTST_W-1:0] v);
        logic signed [OUTST_W-1:0] r;
        r = v[OUTST_W-1] ? '0 : v;
        return r;
    endfunction

endpackage

// ===== src/cca_core.sv =====
module cca_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  cca_pkg::item_t  item,
    input  cca_pkg::cfg_t   cfg,
    output cca_pkg::result_t result
);
    import cca_pkg::*;

    logic signed [OUTST_W-1:0] outst_reg, outst_next;
    logic [JOBS_W-1:0]         prod_reg, prod_next;
    logic [JOBS_W-1:0]         merge_reg, merge_next;
    logic                      flush_reg, flush_next;
    logic                      done_reg, done_next;

    logic signed [WIDE_W-1:0] outst_w, cnt_w, lim_w, cpm_w, sum_w, diff_w, pend_w;
    logic signed [OUTST_W-1:0] dec_chunks;
    logic admit, want, uerr;

    always_comb
    begin
        outst_w    = WIDE_W'(outst_reg);
        cnt_w      = WIDE_W'(item.chunk_count);
        lim_w      = $signed({{(WIDE_W-CFG_W){1'b0}}, cfg.max_outstanding_chunks});
        cpm_w      = $signed({{(WIDE_W-CFG_W){1'b0}}, cfg.chunks_per_merge});
        sum_w      = outst_w + cnt_w;
        diff_w     = outst_w - cnt_w;
        dec_chunks = floor0(sat32(diff_w));

        outst_next = outst_reg;
        prod_next  = prod_reg;
        merge_next = merge_reg;
        flush_next = flush_reg;
        done_next  = done_reg;
        admit      = 1'b0;
        want       = 1'b0;
        uerr       = 1'b0;

        case (item.cmd)
            CMD_ADMIT_QUERY:
            begin
                if ((sum_w <= lim_w) || (cnt_w > lim_w))
                    admit = 1'b1;
                else if ((merge_reg == '0) && (prod_reg == '0))
                    flush_next = 1'b1;
            end
            CMD_MERGE_QUERY:
                want = (cnt_w >= cpm_w) || flush_reg || done_reg;
            CMD_TASK_START:
            begin
                if (prod_reg != JOBS_MAX)
                    prod_next = prod_reg + 1'b1;
                outst_next = sat32(sum_w);
            end
            CMD_TASK_FINISH:
            begin
                if (prod_reg != '0)
                    prod_next = prod_reg - 1'b1;
                outst_next = dec_chunks;
            end
            CMD_ACCOUNT:
                outst_next = sat32(sum_w);
            CMD_MERGE_START:
            begin
                if (merge_reg != JOBS_MAX)
                    merge_next = merge_reg + 1'b1;
                flush_next = 1'b0;
            end
            CMD_MERGE_FINISH:
            begin
                if (merge_reg != '0)
                    merge_next = merge_reg - 1'b1;
                else
                    uerr = 1'b1;
                outst_next = dec_chunks;
            end
            CMD_TASK_DONE:
                done_next = 1'b1;
            default:
                done_next = done_reg;
        endcase

        pend_w = lim_w - WIDE_W'(outst_next);

        result.admit        = admit;
        result.merge_wanted = want;
        if (pend_w[WIDE_W-1])
            result.pending_limit = '0;
        else if (pend_w > PEND_MAX)
            result.pending_limit = '1;
        else
            result.pending_limit = pend_w[CFG_W-1:0];
        result.flush_mode      = flush_next;
        result.done_flag       = done_next;
        result.changed         = (outst_next != outst_reg) || (prod_next != prod_reg) ||
                                 (merge_next != merge_reg) || (flush_next != flush_reg) ||
                                 (done_next != done_reg);
        result.underflow_error = uerr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outst_reg <= '0;
            prod_reg  <= '0;
            merge_reg <= '0;
            flush_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else if (fire)
        begin
            outst_reg <= outst_next;
            prod_reg  <= prod_next;
            merge_reg <= merge_next;
            flush_reg <= flush_next;
            done_reg  <= done_next;
        end
    end

endmodule

// ===== src/chunk_credit_admission_control_top.sv =====
// Chunk credit admission controller.
// Input stream s_*: one event word per handshake; tdata carries cmd in bits
// [2:0] and the signed chunk_count in bits [18:3]. Output stream m_*: one
// result word for every event word, in order. Configuration is written
// through cfg_wr_en / cfg_addr / cfg_wdata (0: max_outstanding_chunks,
// 1: chunks_per_merge) while no event is in flight; other indexes are dropped.
// From input handshake to m_tvalid the event word passes one input register,
// then the event is applied to the counters and its result is captured in the
// output register in the same cycle. Throughput is one word per cycle while
// m_tready is high; counters update by 34-bit add/subtract, saturate, compare.
// Reset clears all counters and flags and loads the limit registers with
// 1000 and 100; both pipeline registers come up empty.
// When the receiver stalls, the result holds on m_tdata, the input register
// still fills, and s_tready drops only once both registers are occupied.
module chunk_credit_admission_control_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cca_pkg::S_TDATA_W-1:0]     s_tdata,   // cmd, chunk_count, zero pad
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cca_pkg::M_TDATA_W-1:0]     m_tdata,   // admit, merge_wanted,
                                                         // pending_limit, flush_mode,
                                                         // done_flag, changed,
                                                         // underflow_error, zero pad
    input  logic                              cfg_wr_en,
    input  logic [cca_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [cca_pkg::CFG_W-1:0]         cfg_wdata
);
    import cca_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_reg;
    cfg_t    cfg_reg;
    result_t core_result;
    logic    fire;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;

    assign m_tdata = {{(M_TDATA_W-22){1'b0}},
                      out_reg.underflow_error, out_reg.changed, out_reg.done_flag,
                      out_reg.flush_mode, out_reg.pending_limit,
                      out_reg.merge_wanted, out_reg.admit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_outstanding_chunks <= MAX_OUTST_RESET;
            cfg_reg.chunks_per_merge       <= CHUNKS_MRG_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_addr))
                REG_MAX_OUTSTANDING:  cfg_reg.max_outstanding_chunks <= cfg_wdata;
                REG_CHUNKS_PER_MERGE: cfg_reg.chunks_per_merge       <= cfg_wdata;
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.cmd         <= cmd_t'(s_tdata[CMD_W-1:0]);
            in_item_reg.chunk_count <= $signed(s_tdata[CMD_W+CNT_W-1:CMD_W]);
        end
    end

    cca_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_reg <= core_result;
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while both stages are full");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !in_valid_reg && !out_valid_reg) |=> ##1 m_tvalid)
        else $error("result missing two cycles after accept into empty pipe");

    a_one_query: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("admit and merge_wanted both set");

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cca_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    chunk_credit_admission_control_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // controller state as the testbench tracks it
    logic [CFG_W-1:0] limit_reg = MAX_OUTST_RESET;
    logic [CFG_W-1:0] merge_size_reg = CHUNKS_MRG_RESET;
    longint           chunks_out = 0;
    int unsigned      producers = 0;
    int unsigned      merges = 0;
    bit               flush_flag = 1'b0;
    bit               done_seen = 1'b0;

    result_t     result_q[$];
    int unsigned errors = 0;
    int unsigned events_sent = 0;
    int unsigned results_seen = 0;
    int unsigned settings_used = 1;
    bit          gaps_on = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned hold_left = 0;

    function automatic longint clamp_i32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic result_t unpack_result(input logic [M_TDATA_W-1:0] d);
        result_t r;
        r.admit           = d[0];
        r.merge_wanted    = d[1];
        r.pending_limit   = d[17:2];
        r.flush_mode      = d[18];
        r.done_flag       = d[19];
        r.changed         = d[20];
        r.underflow_error = d[21];
        return r;
    endfunction

    function automatic result_t apply_event(input cmd_t c, input logic signed [CNT_W-1:0] n);
        longint      cnt;
        longint      lim;
        longint      pend;
        longint      old_chunks;
        int unsigned old_prod;
        int unsigned old_mrg;
        bit          old_flush;
        bit          old_done;
        result_t     r;
        cnt = longint'(n);
        lim = longint'(limit_reg);
        old_chunks = chunks_out;
        old_prod = producers;
        old_mrg = merges;
        old_flush = flush_flag;
        old_done = done_seen;
        r = '0;
        case (c)
            CMD_ADMIT_QUERY:
                if (cnt + chunks_out <= lim || cnt > lim)
                    r.admit = 1'b1;
                else if (merges == 0 && producers == 0)
                    flush_flag = 1'b1;
            CMD_MERGE_QUERY:
                r.merge_wanted = (cnt >= longint'(merge_size_reg)) || flush_flag || done_seen;
            CMD_TASK_START:
            begin
                if (producers < JOBS_MAX)
                    producers++;
                chunks_out = clamp_i32(chunks_out + cnt);
            end
            CMD_TASK_FINISH:
            begin
                if (producers > 0)
                    producers--;
                chunks_out = clamp_i32(chunks_out - cnt);
                if (chunks_out < 0)
                    chunks_out = 0;
            end
            CMD_ACCOUNT:
                chunks_out = clamp_i32(chunks_out + cnt);
            CMD_MERGE_START:
            begin
                if (merges < JOBS_MAX)
                    merges++;
                flush_flag = 1'b0;
            end
            CMD_MERGE_FINISH:
            begin
                if (merges > 0)
                    merges--;
                else
                    r.underflow_error = 1'b1;
                chunks_out = clamp_i32(chunks_out - cnt);
                if (chunks_out < 0)
                    chunks_out = 0;
            end
            default:
                done_seen = 1'b1;
        endcase
        pend = lim - chunks_out;
        if (pend < 0)
            pend = 0;
        if (pend > 65535)
            pend = 65535;
        r.pending_limit = pend[CFG_W-1:0];
        r.flush_mode = flush_flag;
        r.done_flag = done_seen;
        r.changed = (old_chunks != chunks_out) || (old_prod != producers) ||
                    (old_mrg != merges) || (old_flush != flush_flag) ||
                    (old_done != done_seen);
        return r;
    endfunction

    task automatic send_event(input cmd_t c, input logic signed [CNT_W-1:0] n);
        while (gaps_on && $urandom_range(0, 99) < 18)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_TDATA_W - CNT_W - CMD_W){1'b0}}, n, c};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        result_q.push_back(apply_event(c, n));
        events_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_MAX_OUTSTANDING)
            limit_reg = v;
        else if (idx == REG_CHUNKS_PER_MERGE)
            merge_size_reg = v;
        settings_used++;
    endtask

    task automatic random_events(input int unsigned count, input bit with_done);
        cmd_t                    c;
        logic signed [CNT_W-1:0] n;
        int unsigned             pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                c = CMD_ADMIT_QUERY;
            else if (pick < 34)
                c = CMD_MERGE_QUERY;
            else if (pick < 52)
                c = CMD_TASK_START;
            else if (pick < 70)
                c = CMD_TASK_FINISH;
            else if (pick < 80)
                c = CMD_ACCOUNT;
            else if (pick < 89)
                c = CMD_MERGE_START;
            else if (pick < 98 || !with_done)
                c = CMD_MERGE_FINISH;
            else
                c = CMD_TASK_DONE;
            pick = $urandom_range(0, 99);
            if (pick < 12)
                n = CNT_W'($urandom);
            else if (pick < 18)
                n = CNT_W'(-$signed(17'($urandom_range(0, 2000))));
            else
                n = CNT_W'($urandom_range(0, 1200));
            send_event(c, n);
        end
    endtask

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            results_seen++;
            if (result_q.size() == 0)
            begin
                $error("result word with no event pending: %h", m_tdata);
                errors++;
            end
            else
            begin
                compare_result(result_q.pop_front(), unpack_result(m_tdata));
            end
        end
        if (hold_req && hold_left == 0)
        begin
            hold_req <= 1'b0;
            hold_left <= 200;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= (hold_left == 1);
        end
        else
            m_tready <= !(gaps_on && $urandom_range(0, 99) < 18);
    end

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic compare_result(input result_t want, input result_t got);
        check_field("admit", want.admit, got.admit);
        check_field("merge_wanted", want.merge_wanted, got.merge_wanted);
        check_field("pending_limit", want.pending_limit, got.pending_limit);
        check_field("flush_mode", want.flush_mode, got.flush_mode);
        check_field("done_flag", want.done_flag, got.done_flag);
        check_field("changed", want.changed, got.changed);
        check_field("underflow_error", want.underflow_error, got.underflow_error);
    endtask

    task automatic test_directed();
        send_event(CMD_ADMIT_QUERY, 16'sd1000);
        send_event(CMD_ADMIT_QUERY, 16'sd1001);
        send_event(CMD_ACCOUNT, 16'sd600);
        send_event(CMD_ADMIT_QUERY, 16'sd500);
        send_event(CMD_MERGE_QUERY, -16'sd32768);
        send_event(CMD_MERGE_START, 16'sd0);
        send_event(CMD_MERGE_QUERY, 16'sd99);
        send_event(CMD_MERGE_QUERY, 16'sd100);
        send_event(CMD_MERGE_QUERY, 16'sd32767);
        send_event(CMD_TASK_START, 16'sd300);
        send_event(CMD_ADMIT_QUERY, 16'sd200);
        send_event(CMD_TASK_FINISH, -16'sd50);
        send_event(CMD_TASK_FINISH, 16'sd32767);
        send_event(CMD_MERGE_FINISH, 16'sd10);
        send_event(CMD_MERGE_FINISH, 16'sd5);
        send_event(CMD_ACCOUNT, -16'sd32768);
        send_event(CMD_ACCOUNT, -16'sd32768);
        send_event(CMD_ADMIT_QUERY, -16'sd32768);
        send_event(CMD_TASK_START, -16'sd100);
        send_event(CMD_ACCOUNT, 16'sd32767);
        send_event(CMD_ACCOUNT, 16'sd32767);
        send_event(CMD_ACCOUNT, 16'sd32767);
        send_event(CMD_ADMIT_QUERY, 16'sd0);
        send_event(CMD_MERGE_START, -16'sd1);
        write_reg(REG_UNMAPPED, 16'hFFFF);
        send_event(CMD_ADMIT_QUERY, 16'sd1);
    endtask

    task automatic test_register_extremes();
        write_reg(REG_MAX_OUTSTANDING, 16'd0);
        write_reg(REG_CHUNKS_PER_MERGE, 16'd1);
        random_events(60, 1'b0);
        write_reg(REG_MAX_OUTSTANDING, 16'hFFFF);
        write_reg(REG_CHUNKS_PER_MERGE, 16'hFFFF);
        random_events(60, 1'b0);
        write_reg(REG_CHUNKS_PER_MERGE, 16'd0);
        random_events(40, 1'b0);
    endtask

    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_req = 1'b1;
        random_events(40, 1'b0);
        settle();
    endtask

    task automatic test_random();
        write_reg(REG_MAX_OUTSTANDING, 16'd2000);
        write_reg(REG_CHUNKS_PER_MERGE, 16'd150);
        gaps_on = 1'b0;
        random_events(250, 1'b0);
        gaps_on = 1'b1;
        random_events(250, 1'b0);
        write_reg(REG_MAX_OUTSTANDING, 16'd800);
        write_reg(REG_CHUNKS_PER_MERGE, 16'd64);
        random_events(200, 1'b0);
    endtask

    task automatic test_task_done();
        send_event(CMD_MERGE_QUERY, 16'sd0);
        send_event(CMD_TASK_DONE, 16'sh5A5A);
        send_event(CMD_MERGE_QUERY, -16'sd1);
        send_event(CMD_TASK_DONE, 16'sd0);
        random_events(30, 1'b1);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_register_extremes();
        test_backpressure();
        test_random();
        test_task_done();
        settle();
        repeat (10) @(posedge clk);
        $display("Sent %0d events and checked %0d results over %0d register settings,",
                 events_sent, results_seen, settings_used);
        $display("including flush, underflow, saturation and a long output stall.");
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        #3ms;
        $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
src/cca_pkg.sv
src/cca_core.sv
src/chunk_credit_admission_control_top.sv
tb/tb.sv
